[src/gbs_pkg.sv]
// ----------------------------------------------------------------------------
// gbs_pkg - shared types and constants for greedy box suppression
// Item layouts for the box and result channels, pipeline tags, sizes.
// ----------------------------------------------------------------------------
package gbs_pkg;

	localparam int MAX_KEPT_DEF  = 1024;
	localparam int MAX_BOXES_DEF = 16384;

	localparam int COORD_W      = 16;
	localparam int BOX_INDEX_W  = 14;
	localparam int KEPT_COUNT_W = 11;
	localparam int THR_W        = 16;
	localparam int ENTRY_W      = 64;

	localparam logic [THR_W-1:0] IOU_THR_RESET = 16'd42598;

	typedef struct packed {
		logic                      frame_start;
		logic signed [COORD_W-1:0] box_x;
		logic signed [COORD_W-1:0] box_y;
		logic [COORD_W-1:0]        box_w;
		logic [COORD_W-1:0]        box_h;
	} box_t;

	typedef struct packed {
		logic                    keep;
		logic [BOX_INDEX_W-1:0]  box_index;
		logic [KEPT_COUNT_W-1:0] kept_count;
		logic                    store_full;
	} result_t;

	// read issued to the kept store
	typedef struct packed {
		logic valid;
		logic last;
	} scan_tag_t;

	// overlap verdict for one kept entry
	typedef struct packed {
		logic valid;
		logic last;
		logic hit;
	} hit_t;

endpackage

[src/gbs_box_if.sv]
// ----------------------------------------------------------------------------
// gbs_box_if - box channel
// valid/ready handshake carrying one box item.
// ----------------------------------------------------------------------------
interface gbs_box_if import gbs_pkg::*; ();
	logic valid;
	logic ready;
	box_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/gbs_res_if.sv]
// ----------------------------------------------------------------------------
// gbs_res_if - result channel
// valid/ready handshake carrying one suppression result item.
// ----------------------------------------------------------------------------
interface gbs_res_if import gbs_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/greedy_box_suppression.sv]
// ----------------------------------------------------------------------------
// greedy_box_suppression - class-agnostic greedy NMS over Q12.4 boxes
//
//   channel   dir   handshake          payload
//   box_in    in    valid/ready        frame_start, box_x, box_y, box_w, box_h
//   res_out   out   valid/ready        keep, box_index, kept_count, store_full
//   cfg       in    cfg_we             cfg_wdata = iou_threshold (Q0.16)
//
// One box at a time: the kept store, with its single read port, is scanned
// one entry per cycle into a six-stage overlap pipeline; a frame start or an
// empty store skips the scan and goes straight to the result. No
// clearing pass: store contents are only read below the kept count. Results
// sit in an output register, so the next box is taken while a result waits;
// a stalled output holds the box in its final state until the register frees.
// ----------------------------------------------------------------------------
module greedy_box_suppression import gbs_pkg::*; #(
	parameter int MAX_KEPT  = MAX_KEPT_DEF,
	parameter int MAX_BOXES = MAX_BOXES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	gbs_box_if.sink          box_in,
	gbs_res_if.source        res_out,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata
);

	localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int KW = $clog2(MAX_KEPT + 1);
	localparam int CW = $clog2(MAX_BOXES);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]         state_q;
	logic [THR_W-1:0]   thr_q;
	box_t               box_q;
	logic [KW-1:0]      kept_total_q;
	logic [CW-1:0]      box_cnt_q;
	logic [CW-1:0]      box_idx_q;
	logic               full_q;
	logic               supp_q;
	logic [AW-1:0]      rd_idx_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               acc;
	logic [CW-1:0]      cnt_eff;
	logic [CW-1:0]      cnt_next;
	logic               rd_last;
	scan_tag_t          tag;
	logic [ENTRY_W-1:0] entry;
	hit_t               hit;
	logic               slot_free;
	logic               done_fire;
	logic               store_ok;
	logic               mem_we;
	logic [ENTRY_W-1:0] wr_entry;
	logic [KW-1:0]      kept_new;
	logic               full_new;

	assign box_in.ready = (state_q == ST_IDLE);
	assign acc          = box_in.valid && box_in.ready;

	assign cnt_eff  = box_in.data.frame_start ? '0 : box_cnt_q;
	assign cnt_next = (cnt_eff == CW'(MAX_BOXES - 1)) ? '0 : cnt_eff + CW'(1);

	assign rd_last   = (KW'(rd_idx_q) + KW'(1)) == kept_total_q;
	assign tag.valid = (state_q == ST_SCAN);
	assign tag.last  = rd_last;

	assign slot_free = !out_valid_q || res_out.ready;
	assign done_fire = (state_q == ST_DONE) && slot_free;
	assign store_ok  = kept_total_q != KW'(MAX_KEPT);
	assign mem_we    = done_fire && !supp_q && store_ok;
	assign wr_entry  = {box_q.box_y, box_q.box_x, box_q.box_h, box_q.box_w};
	assign kept_new  = mem_we ? kept_total_q + KW'(1) : kept_total_q;
	assign full_new  = full_q || (!supp_q && !store_ok);

	// the write lands at the end of one item; the next item's reads start only
	// after that item has passed through the idle state, so no forwarding is needed
	gbs_kept_mem #(
		.DEPTH (MAX_KEPT),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (kept_total_q[AW-1:0]),
		.wdata (wr_entry),
		.re    (tag.valid),
		.raddr (rd_idx_q),
		.rdata (entry)
	);

	gbs_iou_pipe u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.box    (box_q),
		.thr    (thr_q),
		.tag    (tag),
		.entry  (entry),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			thr_q        <= IOU_THR_RESET;
			kept_total_q <= '0;
			box_cnt_q    <= '0;
			box_idx_q    <= '0;
			full_q       <= 1'b0;
			supp_q       <= 1'b0;
			rd_idx_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (hit.valid && hit.hit) begin
				supp_q <= 1'b1;
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						box_idx_q <= cnt_eff;
						box_cnt_q <= cnt_next;
						supp_q    <= 1'b0;
						rd_idx_q  <= '0;
						if (box_in.data.frame_start) begin
							kept_total_q <= '0;
							full_q       <= 1'b0;
							state_q      <= ST_DONE;
						end else if (kept_total_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_last) begin
						state_q <= ST_WAIT;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				ST_WAIT: begin
					if (hit.valid && hit.last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						kept_total_q <= kept_new;
						full_q       <= full_new;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			box_q <= box_in.data;
		end
		if (done_fire) begin
			out_q.keep       <= !supp_q;
			out_q.box_index  <= BOX_INDEX_W'(box_idx_q);
			out_q.kept_count <= KEPT_COUNT_W'(kept_new);
			out_q.store_full <= full_new;
		end
	end

	assign res_out.valid = out_valid_q;
	assign res_out.data  = out_q;

`ifndef SYNTHESIS
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_total_q <= KW'(MAX_KEPT))
		else $error("kept count beyond store depth");

	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		hit.valid |-> (state_q == ST_SCAN || state_q == ST_WAIT))
		else $error("overlap verdict outside a scan");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && box_in.data.frame_start) |=> (box_idx_q == '0 && kept_total_q == '0))
		else $error("frame start did not clear counters");
`endif

endmodule

[src/gbs_kept_mem.sv]
// ----------------------------------------------------------------------------
// gbs_kept_mem - kept box store
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbs_kept_mem import gbs_pkg::*; #(
	parameter int DEPTH = MAX_KEPT_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/gbs_iou_pipe.sv]
// ----------------------------------------------------------------------------
// gbs_iou_pipe - overlap test pipeline
// One kept entry per cycle: intersection*65536 > threshold*union, exact.
// ----------------------------------------------------------------------------
module gbs_iou_pipe import gbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  box_t               box,
	input  logic [THR_W-1:0]   thr,
	input  scan_tag_t          tag,
	input  logic [ENTRY_W-1:0] entry,
	output hit_t               hit
);

	// overlap of [a0, a0+as) and [b0, b0+bs), zero when empty
	function automatic logic [16:0] ovl(
		input logic signed [15:0] a0,
		input logic [15:0]        as_,
		input logic signed [15:0] b0,
		input logic [15:0]        bs
	);
		logic signed [17:0] ae;
		logic signed [17:0] be;
		logic signed [15:0] lo;
		logic signed [17:0] hi;
		logic signed [18:0] d;
		ae = {{2{a0[15]}}, a0} + $signed({2'b00, as_});
		be = {{2{b0[15]}}, b0} + $signed({2'b00, bs});
		lo = (a0 > b0) ? a0 : b0;
		hi = (ae < be) ? ae : be;
		d  = {hi[17], hi} - {{3{lo[15]}}, lo};
		ovl = (d > 19'sd0) ? d[16:0] : 17'd0;
	endfunction

	scan_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [16:0] ox_s2, oy_s2;
	logic [15:0] bw_s2, bh_s2;
	logic [33:0] inter_s3, inter_s4;
	logic [31:0] areab_s3;
	logic [31:0] area_a_q;
	logic [32:0] uni_s4;
	logic [48:0] prod_s5;
	logic [49:0] lhs_s5;
	logic [34:0] uni_sum;

	// box is held for the whole scan, so its area settles long before use
	always_ff @(posedge clk) begin
		area_a_q <= box.box_w * box.box_h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			hit    <= '0;
		end else begin
			tag_s1    <= tag;
			tag_s2    <= tag_s1;
			tag_s3    <= tag_s2;
			tag_s4    <= tag_s3;
			tag_s5    <= tag_s4;
			hit.valid <= tag_s5.valid;
			hit.last  <= tag_s5.last;
			hit.hit   <= lhs_s5 > {1'b0, prod_s5};
		end
	end

	assign uni_sum = {3'b000, area_a_q} + {3'b000, areab_s3} - {1'b0, inter_s3};

	always_ff @(posedge clk) begin
		ox_s2    <= ovl(box.box_x, box.box_w, $signed(entry[47:32]), entry[15:0]);
		oy_s2    <= ovl(box.box_y, box.box_h, $signed(entry[63:48]), entry[31:16]);
		bw_s2    <= entry[15:0];
		bh_s2    <= entry[31:16];
		inter_s3 <= ox_s2 * oy_s2;
		areab_s3 <= bw_s2 * bh_s2;
		inter_s4 <= inter_s3;
		uni_s4   <= uni_sum[32:0];
		prod_s5  <= thr * uni_s4;
		lhs_s5   <= {inter_s4, 16'h0000};
	end

endmodule

[tb/sv/greedy_box_suppression_tb.sv]
// ----------------------------------------------------------------------------
// greedy_box_suppression_tb - self-checking bench for greedy box suppression
// Drives box items against a cycle-free model of the suppression rule. Covers
// edge boxes, several thresholds and random idling on both channels. Results
// are compared field by field.
// ----------------------------------------------------------------------------
module greedy_box_suppression_tb import gbs_pkg::*; ();

	localparam int RUN_LIMIT_CYCLES = 6000000;
	localparam int RX_HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS     = 135;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we = 1'b0;
	logic [THR_W-1:0] cfg_wdata = '0;

	gbs_box_if box_if ();
	gbs_res_if res_if ();

	greedy_box_suppression dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.box_in    (box_if),
		.res_out   (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// pending boxes and the results they should produce
	box_t        pending_boxes[$];
	result_t     expected_results[$];

	// suppression model state
	box_t             kept_store [MAX_KEPT_DEF];
	int unsigned      kept_n = 0;
	int unsigned      frame_pos = 0;
	bit               store_overflow = 1'b0;
	logic [THR_W-1:0] iou_thr = IOU_THR_RESET;

	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	bit          rx_hold = 1'b0;
	bit          hold_go = 1'b0;
	int unsigned mismatch_count = 0;

	function automatic longint unsigned span_overlap(int a0, int asz, int b0, int bsz);
		int lo;
		int hi;
		lo = (a0 > b0) ? a0 : b0;
		hi = ((a0 + asz) < (b0 + bsz)) ? (a0 + asz) : (b0 + bsz);
		return (hi > lo) ? longint'(hi - lo) : 0;
	endfunction

	function automatic bit suppressed_by(box_t k, box_t b);
		longint unsigned inter;
		longint unsigned area_b;
		longint unsigned area_k;
		longint unsigned uni;
		longint unsigned thr;
		inter = span_overlap(int'($signed(b.box_x)), int'(b.box_w),
			int'($signed(k.box_x)), int'(k.box_w))
			* span_overlap(int'($signed(b.box_y)), int'(b.box_h),
			int'($signed(k.box_y)), int'(k.box_h));
		area_b = b.box_w;
		area_b = area_b * b.box_h;
		area_k = k.box_w;
		area_k = area_k * k.box_h;
		uni = area_b + area_k - inter;
		thr = iou_thr;
		return (inter << 16) > (thr * uni);
	endfunction

	function automatic result_t nms_step(box_t b);
		result_t     r;
		bit          survive;
		int unsigned i;
		if (b.frame_start) begin
			kept_n = 0;
			frame_pos = 0;
			store_overflow = 1'b0;
		end
		r.box_index = frame_pos[BOX_INDEX_W-1:0];
		frame_pos = (frame_pos + 1 >= MAX_BOXES_DEF) ? 0 : frame_pos + 1;
		survive = 1'b1;
		for (i = 0; i < kept_n; i++)
			if (suppressed_by(kept_store[i], b))
				survive = 1'b0;
		if (survive) begin
			if (kept_n < MAX_KEPT_DEF) begin
				kept_store[kept_n] = b;
				kept_n++;
			end else
				store_overflow = 1'b1;
		end
		r.keep = survive;
		r.kept_count = kept_n[KEPT_COUNT_W-1:0];
		r.store_full = store_overflow;
		return r;
	endfunction

	function automatic void report_mismatch(string field, int unsigned want, int unsigned got);
		mismatch_count++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endfunction

	function automatic void check_result(result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			mismatch_count++;
			$error("result item with nothing expected");
			return;
		end
		want = expected_results.pop_front();
		if (got.keep !== want.keep)
			report_mismatch("keep", want.keep, got.keep);
		if (got.box_index !== want.box_index)
			report_mismatch("box_index", want.box_index, got.box_index);
		if (got.kept_count !== want.kept_count)
			report_mismatch("kept_count", want.kept_count, got.kept_count);
		if (got.store_full !== want.store_full)
			report_mismatch("store_full", want.store_full, got.store_full);
	endfunction

	// box driver: predicts at acceptance, then offers the next pending item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_if.valid <= 1'b0;
			box_if.data  <= '0;
		end else begin
			if (box_if.valid && box_if.ready)
				expected_results = {expected_results, nms_step(box_if.data)};
			if (!box_if.valid || box_if.ready) begin
				if (pending_boxes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					box_if.valid <= 1'b1;
					box_if.data  <= pending_boxes.pop_front();
				end else
					box_if.valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_if.ready <= 1'b0;
		else begin
			if (res_if.valid && res_if.ready)
				check_result(res_if.data);
			res_if.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// long receiver hold-off so the block backs up onto its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (RX_HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		repeat (RUN_LIMIT_CYCLES) @(posedge clk);
		$display("greedy_box_suppression_tb NOT OK");
		$finish;
	end

	task automatic push_box(bit fs, int x, int y, int w, int h);
		box_t b;
		b.frame_start = fs;
		b.box_x = 16'(x);
		b.box_y = 16'(y);
		b.box_w = 16'(w);
		b.box_h = 16'(h);
		pending_boxes = {pending_boxes, b};
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_boxes.size() != 0 || box_if.valid || expected_results.size() != 0);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		iou_thr = v;
	endtask

	// frames of clustered boxes, with some full-range noise and stray frame starts
	task automatic push_random_frames(int unsigned n_items);
		int unsigned left;
		int unsigned flen;
		int unsigned j;
		int          cx;
		int          cy;
		int          cw;
		int          ch;
		box_t        b;
		cx = 0;
		cy = 0;
		cw = 16;
		ch = 16;
		left = n_items;
		while (left > 0) begin
			flen = $urandom_range(1, 40);
			if (flen > left)
				flen = left;
			for (j = 0; j < flen; j++) begin
				if ($urandom_range(0, 9) < 2) begin
					b.box_x = 16'($urandom);
					b.box_y = 16'($urandom);
					b.box_w = 16'($urandom);
					b.box_h = 16'($urandom);
				end else begin
					if (j == 0 || $urandom_range(0, 3) == 0) begin
						cx = int'($urandom_range(0, 40000)) - 20000;
						cy = int'($urandom_range(0, 40000)) - 20000;
						cw = int'($urandom_range(16, 3000));
						ch = int'($urandom_range(16, 3000));
					end
					b.box_x = 16'(cx + int'($urandom_range(0, cw / 4)) - cw / 8);
					b.box_y = 16'(cy + int'($urandom_range(0, ch / 4)) - ch / 8);
					b.box_w = 16'(cw + int'($urandom_range(0, cw / 4)) - cw / 8);
					b.box_h = 16'(ch + int'($urandom_range(0, ch / 4)) - ch / 8);
					if ($urandom_range(0, 19) == 0)
						b.box_w = '0;
					if ($urandom_range(0, 19) == 0)
						b.box_h = '0;
				end
				b.frame_start = (j == 0) || ($urandom_range(0, 49) == 0);
				pending_boxes = {pending_boxes, b};
			end
			left -= flen;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		box_if.valid = 1'b0;
		box_if.data = '0;
		res_if.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed edges at the reset threshold
		push_box(1, -32768, -32768, 16'hFFFF, 16'hFFFF);
		push_box(0, 32767, 32767, 16'hFFFF, 16'hFFFF);
		push_box(0, 0, 0, 0, 0);
		push_box(0, 0, 0, 0, 0);
		push_box(0, -32768, -32768, 16'hFFFF, 16'hFFFF);
		push_box(0, 0, 0, 160, 160);
		push_box(0, 16, 0, 160, 160);
		push_box(0, 48, 0, 160, 160);
		push_box(0, 208, 0, 160, 160);
		push_box(0, -1600, -16, 100, 33);
		push_box(0, 1000, 1000, 0, 5000);
		push_box(0, 1000, 1000, 5000, 0);
		push_box(0, 32767, -32768, 1, 16'hFFFF);
		push_box(0, -32768, 32767, 16'hFFFF, 1);
		push_box(1, 0, 0, 160, 160);
		push_box(0, 0, 0, 160, 160);
		push_box(0, 8, 8, 160, 160);
		wait_drained();

		// back-pressure: output held off while boxes keep coming
		push_random_frames(24);
		hold_go = 1'b1;
		wait_drained();

		write_threshold(16'hFFFF);
		push_random_frames(RANDOM_ITEMS);
		wait_drained();

		write_threshold(16'h0000);
		tx_idle_pct = 67;
		push_random_frames(RANDOM_ITEMS);
		wait_drained();

		write_threshold(16'($urandom));
		tx_idle_pct = 0;
		rx_stall_pct = 67;
		push_random_frames(RANDOM_ITEMS);
		wait_drained();

		write_threshold(16'h8000);
		tx_idle_pct = 16;
		rx_stall_pct = 16;
		push_random_frames(RANDOM_ITEMS);
		wait_drained();

		repeat (64) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("greedy_box_suppression_tb OK");
		else
			$display("greedy_box_suppression_tb NOT OK");
		$finish;
	end

endmodule
